/* design/pdvi_pkg.sv */
// Shared types, constants and command codes of the polyline distance interpolator.
package pdvi_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int CHUNK_W          = 17;
    localparam int N_CHUNKS         = 3;
    localparam int OPND_W           = CHUNK_W * N_CHUNKS;
    localparam int DIV_STEPS        = 16;
    localparam int SQRT_STEPS       = 32;
    localparam logic [16:0] T_ONE   = 17'h10000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [4:0]         vertex_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [15:0] vertex_value;
    } t_req;

    typedef struct packed {
        logic [31:0]        distance;
        logic signed [15:0] interpolated_value;
        logic               degenerate_error;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDA,
        S_LATA,
        S_LATB,
        S_MLOAD,
        S_MSTEP,
        S_ACC,
        S_TSEL,
        S_DIV,
        S_BEST,
        S_SQ_INIT,
        S_SQ,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_WRITE,
        DP_START,
        DP_RDA,
        DP_LATA,
        DP_LATB,
        DP_MLOAD,
        DP_MSTEP,
        DP_ACC,
        DP_TSEL,
        DP_DIV,
        DP_BEST,
        DP_SQ_INIT,
        DP_SQ,
        DP_FINISH
    } t_dp_op;

    // product selects, in the order they are evaluated per segment
    typedef enum logic [2:0] {
        M_DXDX,
        M_DYDY,
        M_QXDX,
        M_QYDY,
        M_TDX,
        M_TDY,
        M_EXEX,
        M_EYEY
    } t_msel;

    typedef struct packed {
        t_dp_op     op;
        t_msel      msel;
        logic [4:0] step;
    } t_cmd;

endpackage

/* design/pdvi_ctrl.sv */
// Sequencer: walks the segments and steps the shared datapath units.
module pdvi_ctrl #(
    parameter int MAX_VERTICES = pdvi_pkg::MAX_VERTICES_DEF,
    parameter int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pdvi_pkg::t_op   i_op,
    input  logic            i_cfg_we,
    input  logic [5:0]      i_cfg_wdata,
    output logic            o_busy,
    output pdvi_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_addr
);
    import pdvi_pkg::*;

    t_state        r_state, n_state;
    logic [5:0]    r_vcount;
    logic [AW-1:0] r_seg, n_seg;
    logic [AW-1:0] r_last, n_last;
    logic [4:0]    r_step, n_step;
    t_msel         r_msel, n_msel;
    int            v_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= 6'd2;
            r_seg    <= '0;
            r_last   <= '0;
            r_step   <= '0;
            r_msel   <= M_DXDX;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_last  <= n_last;
            r_step  <= n_step;
            r_msel  <= n_msel;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        if (int'(r_vcount) < 2) begin
            v_eff = 2;
        end else if (int'(r_vcount) > MAX_VERTICES) begin
            v_eff = MAX_VERTICES;
        end else begin
            v_eff = int'(r_vcount);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_seg     = r_seg;
        n_last    = r_last;
        n_step    = r_step;
        n_msel    = r_msel;
        o_cmd.op  = DP_NOP;
        o_cmd.msel = r_msel;
        o_cmd.step = r_step;
        o_addr    = r_seg;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_QUERY) begin
                        o_cmd.op = DP_START;
                        n_seg    = '0;
                        n_last   = AW'(v_eff - 2);
                        n_state  = S_RDA;
                    end else begin
                        o_cmd.op = DP_WRITE;
                    end
                end
            end
            S_RDA: begin
                o_cmd.op = DP_RDA;
                n_state  = S_LATA;
            end
            S_LATA: begin
                o_cmd.op = DP_LATA;
                o_addr   = r_seg + AW'(1);
                n_state  = S_LATB;
            end
            S_LATB: begin
                o_cmd.op = DP_LATB;
                n_msel   = M_DXDX;
                n_state  = S_MLOAD;
            end
            S_MLOAD: begin
                o_cmd.op = DP_MLOAD;
                n_step   = '0;
                n_state  = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.op = DP_MSTEP;
                n_step   = r_step + 5'd1;
                if (int'(r_step) == N_CHUNKS - 1) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = DP_ACC;
                if (r_msel == M_QYDY) begin
                    n_state = S_TSEL;
                end else if (r_msel == M_EYEY) begin
                    n_state = S_BEST;
                end else begin
                    n_msel  = t_msel'(r_msel + 3'd1);
                    n_state = S_MLOAD;
                end
            end
            S_TSEL: begin
                o_cmd.op = DP_TSEL;
                n_step   = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                n_step   = r_step + 5'd1;
                if (int'(r_step) == DIV_STEPS - 1) begin
                    n_msel  = M_TDX;
                    n_state = S_MLOAD;
                end
            end
            S_BEST: begin
                o_cmd.op = DP_BEST;
                if (r_seg == r_last) begin
                    n_state = S_SQ_INIT;
                end else begin
                    n_seg   = r_seg + AW'(1);
                    n_state = S_RDA;
                end
            end
            S_SQ_INIT: begin
                o_cmd.op = DP_SQ_INIT;
                n_step   = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = DP_SQ;
                n_step   = r_step + 5'd1;
                if (int'(r_step) == SQRT_STEPS - 1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = DP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* design/pdvi_dp.sv */
// Datapath: vertex memory, chunked multiplier, divider, square root and search registers.
module pdvi_dp #(
    parameter int MAX_VERTICES = pdvi_pkg::MAX_VERTICES_DEF,
    parameter int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdvi_pkg::t_req  i_req,
    input  pdvi_pkg::t_cmd  i_cmd,
    input  logic [AW-1:0]   i_addr,
    output logic            o_done,
    output pdvi_pkg::t_res  o_res
);
    import pdvi_pkg::*;

    logic [31:0] mem_x [MAX_VERTICES];
    logic [31:0] mem_y [MAX_VERTICES];
    logic [15:0] mem_v [MAX_VERTICES];

    logic signed [31:0] r_rd_x, r_rd_y, r_px, r_py, r_ax, r_ay;
    logic signed [15:0] r_rd_v, r_av, r_bv, r_bst_v0, r_bst_v1;
    logic signed [32:0] r_dx, r_dy, r_qx, r_qy;
    logic [OPND_W-1:0]  r_ma, r_mb;
    logic               r_mneg;
    logic [101:0]       r_acc;
    logic [66:0]        r_len2;
    logic signed [67:0] r_dot;
    logic [67:0]        r_rem;
    logic [16:0]        r_t, r_bst_t;
    logic               r_div_en;
    logic signed [50:0] r_ex, r_ey;
    logic [101:0]       r_e2, r_best;
    logic               r_have, r_degen, r_sat;
    logic [63:0]        r_sq_n;
    logic [34:0]        r_sq_rem;
    logic [31:0]        r_root;
    logic               r_done;
    t_res               r_res;

    logic signed [OPND_W-1:0] sa, sb;
    logic [CHUNK_W-1:0]       chunk;
    logic [101:0]             pp;
    logic signed [102:0]      sp;
    logic signed [50:0]       qx_sh, qy_sh;
    logic [68:0]              rem2;
    logic [34:0]              remx;
    logic [33:0]              trial;
    logic signed [16:0]       vdiff;
    logic signed [33:0]       iprod;
    logic signed [34:0]       isum;

    function automatic logic [OPND_W-1:0] mag(input logic signed [OPND_W-1:0] v);
        return v[OPND_W-1] ? OPND_W'(-v) : OPND_W'(v);
    endfunction

    always_comb begin
        case (i_cmd.msel)
            M_DXDX:  begin sa = OPND_W'(r_dx); sb = OPND_W'(r_dx); end
            M_DYDY:  begin sa = OPND_W'(r_dy); sb = OPND_W'(r_dy); end
            M_QXDX:  begin sa = OPND_W'(r_qx); sb = OPND_W'(r_dx); end
            M_QYDY:  begin sa = OPND_W'(r_qy); sb = OPND_W'(r_dy); end
            M_TDX:   begin sa = OPND_W'($signed({1'b0, r_t})); sb = OPND_W'(r_dx); end
            M_TDY:   begin sa = OPND_W'($signed({1'b0, r_t})); sb = OPND_W'(r_dy); end
            M_EXEX:  begin sa = r_ex; sb = r_ex; end
            M_EYEY:  begin sa = r_ey; sb = r_ey; end
            default: begin sa = '0; sb = '0; end
        endcase
    end

    always_comb begin
        chunk = r_mb[CHUNK_W * int'(i_cmd.step[1:0]) +: CHUNK_W];
        pp    = 102'(r_ma * chunk) << (CHUNK_W * int'(i_cmd.step[1:0]));
        sp    = r_mneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        qx_sh = {{2{r_qx[32]}}, r_qx, 16'b0};
        qy_sh = {{2{r_qy[32]}}, r_qy, 16'b0};
        rem2  = {r_rem, 1'b0};
        remx  = {r_sq_rem[32:0], r_sq_n[63:62]};
        trial = {r_root, 2'b01};
        vdiff = 17'(r_bst_v1) - 17'(r_bst_v0);
        iprod = $signed({1'b0, r_bst_t}) * vdiff;
        isum  = $signed({r_bst_v0, 16'b0}) + 35'(iprod) + 35'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_WRITE && 32'(i_req.vertex_index) < 32'(MAX_VERTICES)) begin
            mem_x[AW'(i_req.vertex_index)] <= i_req.coord_x;
            mem_y[AW'(i_req.vertex_index)] <= i_req.coord_y;
            mem_v[AW'(i_req.vertex_index)] <= i_req.vertex_value;
        end
        if (i_cmd.op == DP_RDA || i_cmd.op == DP_LATA) begin
            r_rd_x <= mem_x[i_addr];
            r_rd_y <= mem_y[i_addr];
            r_rd_v <= mem_v[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_START: begin
                r_px <= i_req.coord_x;
                r_py <= i_req.coord_y;
            end
            DP_LATA: begin
                r_ax <= r_rd_x;
                r_ay <= r_rd_y;
                r_av <= r_rd_v;
                r_qx <= 33'(r_px) - 33'(r_rd_x);
                r_qy <= 33'(r_py) - 33'(r_rd_y);
            end
            DP_LATB: begin
                r_dx <= 33'(r_rd_x) - 33'(r_ax);
                r_dy <= 33'(r_rd_y) - 33'(r_ay);
                r_bv <= r_rd_v;
            end
            DP_MLOAD: begin
                r_ma   <= mag(sa);
                r_mb   <= mag(sb);
                r_mneg <= sa[OPND_W-1] ^ sb[OPND_W-1];
                r_acc  <= '0;
            end
            DP_MSTEP: begin
                r_acc <= r_acc + pp;
            end
            DP_ACC: begin
                case (i_cmd.msel)
                    M_DXDX:  r_len2 <= r_acc[66:0];
                    M_DYDY:  r_len2 <= r_len2 + r_acc[66:0];
                    M_QXDX:  r_dot  <= sp[67:0];
                    M_QYDY:  r_dot  <= r_dot + sp[67:0];
                    M_TDX:   r_ex   <= qx_sh - sp[50:0];
                    M_TDY:   r_ey   <= qy_sh - sp[50:0];
                    M_EXEX:  r_e2   <= r_acc;
                    M_EYEY:  r_e2   <= r_e2 + r_acc;
                    default: r_e2   <= r_e2;
                endcase
            end
            DP_TSEL: begin
                r_rem    <= r_dot;
                r_div_en <= 1'b0;
                if (r_len2 == '0) begin
                    r_t <= '0;
                end else if (r_dot[67] || r_dot == '0) begin
                    r_t <= '0;
                end else if (r_dot[66:0] >= r_len2) begin
                    r_t <= T_ONE;
                end else begin
                    r_t      <= '0;
                    r_div_en <= 1'b1;
                end
            end
            DP_DIV: begin
                if (r_div_en) begin
                    if (rem2 >= {2'b0, r_len2}) begin
                        r_rem <= 68'(rem2 - {2'b0, r_len2});
                        r_t   <= {r_t[15:0], 1'b1};
                    end else begin
                        r_rem <= rem2[67:0];
                        r_t   <= {r_t[15:0], 1'b0};
                    end
                end
            end
            DP_BEST: begin
                if (!r_have || r_e2 < r_best) begin
                    r_best   <= r_e2;
                    r_bst_t  <= r_t;
                    r_bst_v0 <= r_av;
                    r_bst_v1 <= r_bv;
                end
            end
            DP_SQ_INIT: begin
                r_sat    <= |r_best[101:96];
                r_sq_n   <= r_best[95:32];
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            DP_SQ: begin
                r_sq_n <= {r_sq_n[61:0], 2'b00};
                if (remx >= 35'(trial)) begin
                    r_sq_rem <= remx - 35'(trial);
                    r_root   <= {r_root[30:0], 1'b1};
                end else begin
                    r_sq_rem <= remx;
                    r_root   <= {r_root[30:0], 1'b0};
                end
            end
            DP_FINISH: begin
                r_res.distance           <= r_sat ? 32'hFFFF_FFFF : r_root;
                r_res.interpolated_value <= isum[31:16];
                r_res.degenerate_error   <= r_degen;
            end
            default: begin
                r_px <= r_px;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_degen <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == DP_FINISH);
            if (i_cmd.op == DP_START) begin
                r_have  <= 1'b0;
                r_degen <= 1'b0;
            end else if (i_cmd.op == DP_BEST) begin
                r_have <= 1'b1;
            end else if (i_cmd.op == DP_TSEL && r_len2 == '0) begin
                r_degen <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/polyline_distance_value_interpolator.sv */
// Top level: point to polyline distance with value interpolation.
//
//  channel  | ports                        | handshake
//  request  | i_start, o_busy, i_req       | taken when i_start && !o_busy
//  result   | o_done, o_res                | one-cycle strobe, no back-pressure
//  config   | i_cfg_we, i_cfg_wdata        | written when i_cfg_we
//
// A load is written when it is taken and never raises busy. A query keeps busy high until
// its result: for each of the n - 1 segments of n vertices in use, the read states RDA, LATA and
// LATB, 8 products on the shared 17-bit-chunk multiplier, a select state, 16 divider steps
// and a compare; then the square root steps and the result. The strobe comes in the
// cycle busy falls. Reset clears control only; vertex slots hold nothing until loaded.
// The result cannot be stalled.
module polyline_distance_value_interpolator #(
    parameter int MAX_VERTICES = pdvi_pkg::MAX_VERTICES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  pdvi_pkg::t_req  i_req,
    output logic            o_done,
    output pdvi_pkg::t_res  o_res,
    input  logic            i_cfg_we,
    input  logic [5:0]      i_cfg_wdata
);
    import pdvi_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    t_cmd          cmd;
    logic [AW-1:0] addr;

    pdvi_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_op        (i_req.operation),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (o_busy),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    pdvi_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

/* verif/tb_polyline_distance_value_interpolator.sv */
// Testbench for the polyline distance interpolator: random and directed loads and queries.
`timescale 1ns / 1ps

module tb_polyline_distance_value_interpolator;
    import pdvi_pkg::*;

    typedef logic signed [127:0] t_wide;

    localparam int NVERT = MAX_VERTICES_DEF;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    t_req       i_req = '0;
    logic       o_done;
    t_res       o_res;
    logic       i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;

    polyline_distance_value_interpolator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    t_req               pending_reqs[$];
    t_res               expected_res[$];
    logic signed [31:0] vx[NVERT];
    logic signed [31:0] vy[NVERT];
    logic signed [15:0] vval[NVERT];
    logic [5:0]         vertex_count = 6'd2;
    int                 errors = 0;
    int                 n_loads = 0;
    int                 n_queries = 0;
    int                 n_degen = 0;
    int                 n_sat = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;

    // generator-side copy of the polyline
    logic signed [31:0] gx[NVERT];
    logic signed [31:0] gy[NVERT];

    function automatic logic [31:0] isqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic t_res nearest_point(input t_req r);
        t_res   res;
        int     n;
        longint ax, ay, dx, dy, qx, qy, t, ex, ey, best_t, s;
        t_wide  len2, dot, e2, best;
        int     best_seg;
        logic   degen;
        n = (vertex_count < 2) ? 2 : (vertex_count > NVERT) ? NVERT : int'(vertex_count);
        degen = 1'b0;
        best = '0;
        best_t = 0;
        best_seg = 0;
        for (int seg = 0; seg + 1 < n; seg++) begin
            ax = longint'(vx[seg]);
            ay = longint'(vy[seg]);
            dx = longint'(vx[seg + 1]) - ax;
            dy = longint'(vy[seg + 1]) - ay;
            qx = longint'(r.coord_x) - ax;
            qy = longint'(r.coord_y) - ay;
            len2 = t_wide'(dx) * t_wide'(dx) + t_wide'(dy) * t_wide'(dy);
            dot = t_wide'(qx) * t_wide'(dx) + t_wide'(qy) * t_wide'(dy);
            if (len2 == 0) begin
                degen = 1'b1;
                t = 0;
            end else if (dot <= 0) begin
                t = 0;
            end else if (dot >= len2) begin
                t = 65536;
            end else begin
                t = longint'((dot * 65536) / len2);
            end
            ex = qx * 65536 - t * dx;
            ey = qy * 65536 - t * dy;
            e2 = t_wide'(ex) * t_wide'(ex) + t_wide'(ey) * t_wide'(ey);
            if (seg == 0 || e2 < best) begin
                best = e2;
                best_t = t;
                best_seg = seg;
            end
        end
        if (best[127:96] != 0) res.distance = 32'hFFFF_FFFF;
        else res.distance = isqrt(best[95:32]);
        s = (65536 - best_t) * longint'(vval[best_seg]) + best_t * longint'(vval[best_seg + 1]);
        s = (s + 32768) >>> 16;
        res.interpolated_value = s[15:0];
        res.degenerate_error = degen;
        return res;
    endfunction

    // driver: bursts with random gaps; model update or prediction on each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                if (i_req.operation == OP_LOAD) begin
                    vx[i_req.vertex_index] = i_req.coord_x;
                    vy[i_req.vertex_index] = i_req.coord_y;
                    vval[i_req.vertex_index] = i_req.vertex_value;
                    n_loads++;
                end else begin
                    expected_res = {expected_res, nearest_point(i_req)};
                    n_queries++;
                end
            end
            if (i_start && o_busy) begin
                // hold the request
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                i_start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                $error("result with none expected: distance %h", o_res.distance);
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                if (o_res.distance != e.distance) begin
                    $error("distance: expected %h, got %h", e.distance, o_res.distance);
                    errors++;
                end
                if (o_res.interpolated_value != e.interpolated_value) begin
                    $error("interpolated_value: expected %h, got %h",
                           e.interpolated_value, o_res.interpolated_value);
                    errors++;
                end
                if (o_res.degenerate_error != e.degenerate_error) begin
                    $error("degenerate_error: expected %b, got %b",
                           e.degenerate_error, o_res.degenerate_error);
                    errors++;
                end
                if (e.degenerate_error) n_degen++;
                if (e.distance == 32'hFFFF_FFFF) n_sat++;
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        endcase
    endfunction

    task automatic push_load(input int slot, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [15:0] v);
        t_req r;
        r.operation = OP_LOAD;
        r.vertex_index = slot[4:0];
        r.coord_x = x;
        r.coord_y = y;
        r.vertex_value = v;
        gx[slot] = x;
        gy[slot] = y;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic push_query(input logic signed [31:0] x, input logic signed [31:0] y);
        t_req r;
        r.operation = OP_QUERY;
        r.vertex_index = 5'($urandom());
        r.coord_x = x;
        r.coord_y = y;
        r.vertex_value = 16'($urandom());
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_start || expected_res.size() > 0 || o_busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [5:0] c);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vertex_count = c;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [5:0] c, input int n_items);
        int n;
        int k;
        n = (c < 2) ? 2 : (c > NVERT) ? NVERT : int'(c);
        write_count(c);
        for (int i = 0; i < n; i++)
            push_load(i, rand_coord(), rand_coord(), 16'($urandom()));
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                0: push_load($urandom_range(0, 31), rand_coord(), rand_coord(),
                             16'($urandom()));
                1: push_load(k, (k > 0) ? gx[k - 1] : gx[1], (k > 0) ? gy[k - 1] : gy[1],
                             16'($urandom()));
                2: push_query(rand_coord(), rand_coord());
                default: push_query(gx[k] + ($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000),
                                    gy[k] + ($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000));
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset count of two vertices
        push_load(0, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000);
        push_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF);
        push_query(32'sh0, 32'sh0);
        push_query(32'sh8000_0000, 32'sh7FFF_FFFF);
        push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_load(0, 32'sh0, 32'sh0, 16'sh4000);
        push_load(1, 32'sh0001_0000, 32'sh0, 16'shC000);
        push_query(32'sh0000_8000, 32'sh0003_0000);
        push_query(32'shFFFF_0000, 32'sh0);
        push_query(32'sh0002_0000, 32'shFFFF_FFFF);
        push_query(32'sh7FFF_FFFF, 32'sh0);
        push_load(1, 32'sh0, 32'sh0, 16'sh7FFF);
        push_query(32'sh0001_0000, 32'sh0001_0000);
        push_load(31, 32'sh1234_5678, 32'shEDCB_A987, 16'sh0001);

        random_phase(6'd0, 30);
        random_phase(6'd1, 30);
        random_phase(6'd3, 60);
        random_phase(6'd63, 12);
        random_phase(6'd2, 60);
        random_phase(6'd32, 12);
        random_phase(6'd33, 8);
        random_phase(6'd5, 60);
        random_phase(6'($urandom_range(2, 12)), 60);
        random_phase(6'd17, 20);

        wait_idle();
        repeat (2100) @(posedge i_clk);
        $display("Covered %0d loads and %0d queries over several vertex counts,", n_loads,
                 n_queries);
        $display("%0d with a zero-length segment and %0d with saturated distance.", n_degen,
                 n_sat);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
